### rtl/gbfs_pkg.sv
package gbfs_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int CRD_W          = 7;

	localparam logic [15:0] DIST_FAR  = 16'd32767;
	localparam logic [15:0] DIST_WALL = 16'hFFFF;
	localparam logic [15:0] DIST_GOAL = 16'd1;

	localparam logic [2:0] DIR_STAY  = 3'd0;
	localparam logic [2:0] DIR_UP    = 3'd1;
	localparam logic [2:0] DIR_RIGHT = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;
	localparam logic [2:0] DIR_LEFT  = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic KIND_READY = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GOAL_X      = 2'd2;
	localparam logic [1:0] REG_GOAL_Y      = 2'd3;

	typedef struct packed {
		logic       command;
		logic       cell_open;
		logic       last_cell;
		logic [5:0] pos_x;
		logic [5:0] pos_y;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] next_x;
		logic [5:0] next_y;
		logic [2:0] direction;
		logic       at_goal;
	} result_t;

	typedef struct packed {
		logic       load_we;
		logic       load_clr;
		logic       sweep_step;
		logic       q_reset;
		logic       q_rd;
		logic       base_goal;
		logic       base_pos;
		logic       base_queue;
		logic       addr_en;
		logic [2:0] sel;
		logic       dist_rd;
		logic       relax;
		logic       v_load;
		logic       qry_center;
		logic       qry_nb;
		logic       out_ready;
		logic       out_step;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic q_empty;
		logic tvalid;
		logic is_goal;
	} sts_t;

endpackage

### rtl/gbfs_ctrl.sv
module gbfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbfs_pkg::item_t item,
	input  gbfs_pkg::sts_t  sts,
	output gbfs_pkg::cmd_t  cmd,
	output logic            busy
);
	import gbfs_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SWEEP  = 4'd1;
	localparam logic [3:0] ST_C_ADDR = 4'd2;
	localparam logic [3:0] ST_C_RD   = 4'd3;
	localparam logic [3:0] ST_C_CHK  = 4'd4;
	localparam logic [3:0] ST_N_ADDR = 4'd5;
	localparam logic [3:0] ST_N_RD   = 4'd6;
	localparam logic [3:0] ST_N_CHK  = 4'd7;
	localparam logic [3:0] ST_P_CHK  = 4'd8;
	localparam logic [3:0] ST_POP    = 4'd9;
	localparam logic [3:0] ST_READY  = 4'd10;
	localparam logic [3:0] ST_Q_OUT  = 4'd11;

	localparam logic [1:0] MODE_SEED = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_QRY  = 2'd2;

	logic [3:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic [2:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_SEED;
			sel_q   <= DIR_STAY;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.command == CMD_LOAD) begin
						cmd.load_we = 1'b1;
						if (item.last_cell) begin
							cmd.q_reset = 1'b1;
							state_d     = ST_SWEEP;
						end
					end else begin
						cmd.base_pos = 1'b1;
						mode_d       = MODE_QRY;
						state_d      = ST_C_ADDR;
					end
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					cmd.base_goal = 1'b1;
					mode_d        = MODE_SEED;
					state_d       = ST_C_ADDR;
				end
			end
			ST_C_ADDR: begin
				cmd.sel     = DIR_STAY;
				cmd.addr_en = 1'b1;
				state_d     = ST_C_RD;
			end
			ST_C_RD: begin
				cmd.dist_rd = 1'b1;
				state_d     = ST_C_CHK;
			end
			ST_C_CHK: begin
				sel_d = DIR_RIGHT;
				unique case (mode_q)
					MODE_SEED: begin
						cmd.relax = 1'b1;
						state_d   = ST_P_CHK;
					end
					MODE_POP: begin
						cmd.v_load = 1'b1;
						state_d    = ST_N_ADDR;
					end
					default: begin
						cmd.qry_center = 1'b1;
						if (!sts.tvalid || sts.is_goal) begin
							state_d = ST_Q_OUT;
						end else begin
							state_d = ST_N_ADDR;
						end
					end
				endcase
			end
			ST_N_ADDR: begin
				cmd.addr_en = 1'b1;
				state_d     = ST_N_RD;
			end
			ST_N_RD: begin
				cmd.dist_rd = 1'b1;
				state_d     = ST_N_CHK;
			end
			ST_N_CHK: begin
				if (mode_q == MODE_QRY) begin
					cmd.qry_nb = 1'b1;
				end else begin
					cmd.relax = 1'b1;
				end
				unique case (sel_q)
					DIR_RIGHT: begin
						sel_d   = DIR_LEFT;
						state_d = ST_N_ADDR;
					end
					DIR_LEFT: begin
						sel_d   = DIR_DOWN;
						state_d = ST_N_ADDR;
					end
					DIR_DOWN: begin
						sel_d   = DIR_UP;
						state_d = ST_N_ADDR;
					end
					default: begin
						state_d = (mode_q == MODE_QRY) ? ST_Q_OUT : ST_P_CHK;
					end
				endcase
			end
			ST_P_CHK: begin
				if (sts.q_empty) begin
					state_d = ST_READY;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = ST_POP;
				end
			end
			ST_POP: begin
				cmd.base_queue = 1'b1;
				mode_d         = MODE_POP;
				state_d        = ST_C_ADDR;
			end
			ST_READY: begin
				cmd.out_ready = 1'b1;
				cmd.load_clr  = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_Q_OUT: begin
				cmd.out_step = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/gbfs_dp.sv
module gbfs_dp #(
	parameter int MAX_WIDTH  = gbfs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gbfs_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbfs_pkg::cmd_t    cmd,
	output gbfs_pkg::sts_t    sts,
	input  gbfs_pkg::item_t   item,
	input  logic [6:0]        grid_width,
	input  logic [6:0]        grid_height,
	input  logic [5:0]        goal_x,
	input  logic [5:0]        goal_y,
	output gbfs_pkg::result_t result,
	output logic              strobe
);
	import gbfs_pkg::*;

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = AW + 1;
	localparam int NW    = (SW > 14) ? SW : 14;
	localparam int PW    = (AW > 14) ? AW + 1 : 15;

	logic                  om_mem [CELLS];
	logic [15:0]           dist_mem [CELLS];
	logic [2*CRD_W-1:0]    q_mem [CELLS];

	logic [CRD_W-1:0]      w_eff, h_eff;
	logic [NW-1:0]         n_cells;
	logic [SW-1:0]         load_q, sweep_q, head_q, tail_q;
	logic                  sw_v_s1, om_s1, in_s1;
	logic [AW-1:0]         sw_idx_s1;
	logic [15:0]           sw_data;
	logic [CRD_W-1:0]      bx_q, by_q, tx, ty, tx_q, ty_q, nx, ny;
	logic                  tv, tv_q;
	logic [PW-1:0]         addr_full;
	logic [AW-1:0]         addr_q;
	logic [15:0]           rd_q, v_q, best_q;
	logic [2*CRD_W-1:0]    qd_q;
	logic                  relax_we, load_ok;
	logic                  goal_q, bv_q;
	logic [2:0]            dir_q;
	result_t               result_q;
	logic                  strobe_q;

	always_comb begin
		w_eff = grid_width;
		if (grid_width == '0) begin
			w_eff = 7'd1;
		end else if (32'(grid_width) > MAX_WIDTH) begin
			w_eff = 7'(MAX_WIDTH);
		end
		h_eff = grid_height;
		if (grid_height == '0) begin
			h_eff = 7'd1;
		end else if (32'(grid_height) > MAX_HEIGHT) begin
			h_eff = 7'(MAX_HEIGHT);
		end
	end

	assign n_cells  = NW'(w_eff) * NW'(h_eff);
	assign load_ok  = NW'(load_q) < n_cells;
	assign sw_data  = (in_s1 && om_s1) ? DIST_FAR : DIST_WALL;
	assign relax_we = cmd.relax && tv_q && (rd_q != DIST_WALL) && (rd_q > v_q);

	always_comb begin
		tx = bx_q;
		ty = by_q;
		tv = (bx_q < w_eff) && (by_q < h_eff);
		unique case (cmd.sel)
			DIR_RIGHT: begin
				tx = bx_q + CRD_W'(1);
				tv = tv && (tx < w_eff);
			end
			DIR_LEFT: begin
				tx = bx_q - CRD_W'(1);
				tv = tv && (bx_q != '0);
			end
			DIR_DOWN: begin
				ty = by_q + CRD_W'(1);
				tv = tv && (ty < h_eff);
			end
			DIR_UP: begin
				ty = by_q - CRD_W'(1);
				tv = tv && (by_q != '0);
			end
			default: begin
			end
		endcase
	end

	assign addr_full = PW'(ty) * PW'(w_eff) + PW'(tx);

	always_comb begin
		nx = bx_q;
		ny = by_q;
		unique case (dir_q)
			DIR_RIGHT: nx = bx_q + CRD_W'(1);
			DIR_LEFT:  nx = bx_q - CRD_W'(1);
			DIR_DOWN:  ny = by_q + CRD_W'(1);
			DIR_UP:    ny = by_q - CRD_W'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we && load_ok) begin
			om_mem[load_q[AW-1:0]] <= item.cell_open;
		end
		if (cmd.sweep_step) begin
			om_s1     <= om_mem[sweep_q[AW-1:0]];
			in_s1     <= NW'(sweep_q) < n_cells;
			sw_idx_s1 <= sweep_q[AW-1:0];
		end
		if (sw_v_s1) begin
			dist_mem[sw_idx_s1] <= sw_data;
		end else if (relax_we) begin
			dist_mem[addr_q] <= v_q;
		end
		if (relax_we) begin
			q_mem[tail_q[AW-1:0]] <= {ty_q, tx_q};
		end
		if (cmd.q_rd) begin
			qd_q <= q_mem[head_q[AW-1:0]];
		end
		if (cmd.addr_en) begin
			addr_q <= addr_full[AW-1:0];
			tv_q   <= tv;
			tx_q   <= tx;
			ty_q   <= ty;
		end
		if (cmd.dist_rd) begin
			rd_q <= dist_mem[addr_q];
		end
		if (cmd.base_goal) begin
			bx_q <= CRD_W'(goal_x);
			by_q <= CRD_W'(goal_y);
			v_q  <= DIST_GOAL;
		end else if (cmd.base_pos) begin
			bx_q <= CRD_W'(item.pos_x);
			by_q <= CRD_W'(item.pos_y);
		end else if (cmd.base_queue) begin
			{by_q, bx_q} <= qd_q;
		end
		if (cmd.v_load) begin
			v_q <= rd_q + 16'd1;
		end
		if (cmd.qry_center) begin
			goal_q <= tv_q && (rd_q == DIST_GOAL);
			dir_q  <= DIR_STAY;
			bv_q   <= 1'b0;
		end else if (cmd.qry_nb && tv_q && (rd_q != DIST_WALL) && (!bv_q || rd_q < best_q)) begin
			best_q <= rd_q;
			bv_q   <= 1'b1;
			dir_q  <= cmd.sel;
		end
		if (cmd.out_ready) begin
			result_q <= '{kind: KIND_READY, next_x: '0, next_y: '0,
				direction: DIR_STAY, at_goal: 1'b0};
		end else if (cmd.out_step) begin
			result_q <= '{kind: KIND_STEP, next_x: nx[5:0], next_y: ny[5:0],
				direction: dir_q, at_goal: goal_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= '0;
			sweep_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			sw_v_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			sw_v_s1  <= cmd.sweep_step;
			strobe_q <= cmd.out_ready || cmd.out_step;
			if (cmd.load_clr) begin
				load_q <= '0;
			end else if (cmd.load_we && load_ok) begin
				load_q <= load_q + SW'(1);
			end
			if (cmd.q_reset) begin
				sweep_q <= '0;
				head_q  <= '0;
				tail_q  <= '0;
			end else begin
				if (cmd.sweep_step) begin
					sweep_q <= sweep_q + SW'(1);
				end
				if (cmd.q_rd) begin
					head_q <= head_q + SW'(1);
				end
				if (relax_we) begin
					tail_q <= tail_q + SW'(1);
				end
			end
		end
	end

	assign sts.sweep_last = (sweep_q == SW'(CELLS - 1));
	assign sts.q_empty    = (head_q == tail_q);
	assign sts.tvalid     = tv_q;
	assign sts.is_goal    = (rd_q == DIST_GOAL);
	assign result         = result_q;
	assign strobe         = strobe_q;

endmodule

### rtl/grid_bfs_distance_and_step_top.sv
// Load item: no result, and the block stays idle. Last load: clears the distance
// map over all MAX_WIDTH*MAX_HEIGHT cells, then floods one reached cell at a time;
// the ready result follows once the flood queue is empty.
// Step query: reads the cell, then its 4 neighbours unless off grid or at goal.
// One item at a time; the single-port distance memory sets the pace; no output stall.
// Asynchronous active-low reset clears control state and loads register defaults.
module grid_bfs_distance_and_step_top #(
	parameter int MAX_WIDTH  = gbfs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gbfs_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gbfs_pkg::item_t   item,
	output logic              strobe,
	output gbfs_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import gbfs_pkg::*;

	logic [6:0] grid_width_q, grid_height_q;
	logic [5:0] goal_x_q, goal_y_q;
	logic       cfg_we;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
			goal_x_q      <= 6'd1;
			goal_y_q      <= 6'd1;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[6:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[6:0];
				REG_GOAL_X:      goal_x_q      <= pwdata[5:0];
				default:         goal_y_q      <= pwdata[5:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			REG_GOAL_X:      prdata = 32'(goal_x_q);
			default:         prdata = 32'(goal_y_q);
		endcase
	end

	gbfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	gbfs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item        (item),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.goal_x      (goal_x_q),
		.goal_y      (goal_y_q),
		.result      (result),
		.strobe      (strobe)
	);

`ifndef SYNTHESIS
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.command == CMD_STEP) |=> busy)
		else $error("query transaction did not start work");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.command == CMD_LOAD && !item.last_cell) |=> !busy)
		else $error("plain load left block busy");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while busy");
`endif

endmodule

### dv/grid_bfs_distance_and_step_checker.sv
`timescale 1ns / 100ps
module grid_bfs_distance_and_step_checker
	import gbfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        strobe,
	input  result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	bit          open_cells [CELLS];
	logic [15:0] dist_map [CELLS];
	int          flood_q [CELLS];
	int          q_tail;
	int          load_idx;
	logic [6:0]  width_reg, height_reg;
	logic [5:0]  goal_x_reg, goal_y_reg;
	result_t     expected_q [$];

	function automatic int eff_w();
		if (width_reg < 1) return 1;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_h();
		if (height_reg < 1) return 1;
		if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic void relax(int x, int y, int v, int w, int h);
		int idx;
		if (x < 0 || y < 0 || x >= w || y >= h) return;
		idx = y * w + x;
		if (dist_map[idx] == DIST_WALL) return;
		if (dist_map[idx] > v) begin
			dist_map[idx] = v[15:0];
			if (q_tail < CELLS) begin
				flood_q[q_tail] = idx;
				q_tail++;
			end
		end
	endfunction

	function automatic void flood_distances();
		int w, h, hd, idx, v;
		w = eff_w();
		h = eff_h();
		for (int i = 0; i < CELLS; i++)
			dist_map[i] = (i < w * h && open_cells[i]) ? DIST_FAR : DIST_WALL;
		hd = 0;
		q_tail = 0;
		relax(int'(goal_x_reg), int'(goal_y_reg), 1, w, h);
		while (hd < q_tail) begin
			idx = flood_q[hd];
			v = int'(dist_map[idx]) + 1;
			relax(idx % w + 1, idx / w, v, w, h);
			relax(idx % w - 1, idx / w, v, w, h);
			relax(idx % w, idx / w + 1, v, w, h);
			relax(idx % w, idx / w - 1, v, w, h);
			hd++;
		end
	endfunction

	function automatic int nb_dist(int x, int y, int w, int h);
		if (x < 0 || y < 0 || x >= w || y >= h) return -1;
		if (dist_map[y * w + x] == DIST_WALL) return -1;
		return int'(dist_map[y * w + x]);
	endfunction

	function automatic void predict_step(item_t it);
		int w, h, x, y, best, d;
		result_t r;
		w = eff_w();
		h = eff_h();
		r = '0;
		if (it.command == CMD_LOAD) begin
			if (load_idx < w * h) begin
				open_cells[load_idx] = it.cell_open;
				load_idx++;
			end
			if (!it.last_cell) return;
			flood_distances();
			load_idx = 0;
			r.kind = KIND_READY;
			expected_q.push_back(r);
			return;
		end
		x = int'(it.pos_x);
		y = int'(it.pos_y);
		r.kind = KIND_STEP;
		r.direction = DIR_STAY;
		if (x < w && y < h) begin
			if (dist_map[y * w + x] == DIST_GOAL) begin
				r.at_goal = 1'b1;
			end else begin
				best = 32'h7fffffff;
				d = nb_dist(x + 1, y, w, h);
				if (d >= 0) begin best = d; r.direction = DIR_RIGHT; end
				d = nb_dist(x - 1, y, w, h);
				if (d >= 0 && d < best) begin best = d; r.direction = DIR_LEFT; end
				d = nb_dist(x, y + 1, w, h);
				if (d >= 0 && d < best) begin best = d; r.direction = DIR_DOWN; end
				d = nb_dist(x, y - 1, w, h);
				if (d >= 0 && d < best) begin best = d; r.direction = DIR_UP; end
				case (r.direction)
					DIR_UP:    y--;
					DIR_RIGHT: x++;
					DIR_DOWN:  y++;
					DIR_LEFT:  x--;
					default: ;
				endcase
			end
		end
		r.next_x = x[5:0];
		r.next_y = y[5:0];
		expected_q.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			fails = 0;
			pending = 0;
			load_idx = 0;
			width_reg = 7'd64;
			height_reg = 7'd64;
			goal_x_reg = 6'd1;
			goal_y_reg = 6'd1;
			expected_q.delete();
		end else begin
			if (strobe) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					fails++;
				end else begin
					exp_r = expected_q.pop_front();
					if (result.kind !== exp_r.kind || result.next_x !== exp_r.next_x ||
						result.next_y !== exp_r.next_y ||
						result.direction !== exp_r.direction ||
						result.at_goal !== exp_r.at_goal) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, result);
						fails++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_GRID_WIDTH:  width_reg = pwdata[6:0];
					REG_GRID_HEIGHT: height_reg = pwdata[6:0];
					REG_GOAL_X:      goal_x_reg = pwdata[5:0];
					REG_GOAL_Y:      goal_y_reg = pwdata[5:0];
					default: ;
				endcase
			end
			if (start && !busy)
				predict_step(item);
			pending = expected_q.size();
		end
	end

endmodule

### dv/grid_bfs_distance_and_step_top_tb.sv
`timescale 1ns / 100ps
module grid_bfs_distance_and_step_top_tb;
	import gbfs_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        strobe;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fails, pending;
	int          cycles = 0;
	int          items_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	grid_bfs_distance_and_step_top u_top (
		.clk, .arst_n, .start, .busy, .item, .strobe, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	grid_bfs_distance_and_step_checker u_checker (
		.clk, .arst_n, .start, .busy, .item, .strobe, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fails, .pending
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(item_t it, bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item = it;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	initial begin
		int w, h, gx, gy, extra, total, n_q, open_pct;
		bit goal_wall, no_gaps;
		item_t it;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < 10 || items_sent < 1100; ph++) begin
			extra = 0;
			goal_wall = 0;
			open_pct = 75;
			no_gaps = (ph % 4 == 3);
			case (ph)
				0: begin w = 64; h = 4; gx = 1; gy = 1; open_pct = 12; end
				1: begin w = 1; h = 1; gx = 0; gy = 0; end
				2: begin w = 0; h = 127; gx = 0; gy = 63; end
				3: begin w = 64; h = 1; gx = 63; gy = 0; end
				4: begin w = 5; h = 5; gx = 7; gy = 2; end
				5: begin w = 6; h = 4; gx = 2; gy = 3; goal_wall = 1; end
				6: begin w = 4; h = 3; gx = 1; gy = 0; extra = 3; end
				7: begin w = 127; h = 2; gx = 40; gy = 1; end
				default: begin
					w = $urandom_range(2, 12);
					h = $urandom_range(2, 12);
					gx = $urandom_range(0, w - 1);
					gy = $urandom_range(0, h - 1);
					goal_wall = ($urandom_range(0, 9) == 0);
					extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
					open_pct = $urandom_range(55, 95);
				end
			endcase
			reg_write(REG_GRID_WIDTH, w);
			reg_write(REG_GRID_HEIGHT, h);
			reg_write(REG_GOAL_X, gx);
			reg_write(REG_GOAL_Y, gy);
			if (w < 1) w = 1;
			if (w > 64) w = 64;
			if (h < 1) h = 1;
			if (h > 64) h = 64;
			total = w * h + extra;
			for (int i = 0; i < total; i++) begin
				it = item_t'(15'($urandom));
				it.command = CMD_LOAD;
				it.cell_open = ($urandom_range(0, 99) < open_pct);
				if (i == gy * w + gx && gx < w && gy < h) it.cell_open = !goal_wall;
				it.last_cell = (i == total - 1);
				send(it, no_gaps);
			end
			n_q = (ph == 0) ? 60 : $urandom_range(20, 50);
			for (int q = 0; q < n_q; q++) begin
				it = item_t'(15'($urandom));
				it.command = CMD_STEP;
				if (q == 0) begin
					it.pos_x = 6'(gx);
					it.pos_y = 6'(gy);
				end else if ($urandom_range(0, 9) != 0) begin
					it.pos_x = 6'($urandom_range(0, w - 1));
					it.pos_y = 6'($urandom_range(0, h - 1));
				end
				send(it, no_gaps);
			end
			drain();
		end
		drain();
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
rtl/gbfs_pkg.sv
rtl/gbfs_ctrl.sv
rtl/gbfs_dp.sv
rtl/grid_bfs_distance_and_step_top.sv
dv/grid_bfs_distance_and_step_checker.sv
dv/grid_bfs_distance_and_step_top_tb.sv
